FILE: sv/json_keyed_object_line_scanner_defines.svh
// Assertion macros shared by the scanner's checker.
`ifndef JSON_KEYED_OBJECT_LINE_SCANNER_DEFINES_SVH
`define JSON_KEYED_OBJECT_LINE_SCANNER_DEFINES_SVH

// Property checked only while reset is released.
`define JKOS_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define JKOS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: sv/jkos_pkg.sv
// Shared types, constants and helper functions of the keyed-object line scanner.
package jkos_pkg;

    localparam int MAX_NESTING = 255;
    localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
    localparam int CU_W        = 16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_KEY_CHAR = 3'd0;
    localparam kind_t KIND_KEY_END  = 3'd1;
    localparam kind_t KIND_BODY     = 3'd2;
    localparam kind_t KIND_ACCEPT   = 3'd3;
    localparam kind_t KIND_ERROR    = 3'd4;

    localparam logic [CU_W-1:0] CH_QUOTE  = 16'h0022;
    localparam logic [CU_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CU_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CU_W-1:0] CH_LBRACE = 16'h007B;
    localparam logic [CU_W-1:0] CH_RBRACE = 16'h007D;
    localparam logic [CU_W-1:0] CH_COLON  = 16'h003A;
    localparam logic [CU_W-1:0] CH_COMMA  = 16'h002C;
    localparam logic [CU_W-1:0] CH_LOW_B  = 16'h0062;
    localparam logic [CU_W-1:0] CH_LOW_F  = 16'h0066;
    localparam logic [CU_W-1:0] CH_LOW_N  = 16'h006E;
    localparam logic [CU_W-1:0] CH_LOW_R  = 16'h0072;
    localparam logic [CU_W-1:0] CH_LOW_T  = 16'h0074;
    localparam logic [CU_W-1:0] CH_LOW_U  = 16'h0075;

    typedef enum logic [3:0] {
        PH_START,
        PH_KEY,
        PH_KEY_ESC,
        PH_KEY_HEX,
        PH_AFTER_KEY,
        PH_AFTER_COL,
        PH_BODY,
        PH_AFTER_BODY,
        PH_NEXT_KEY,
        PH_AFTER_CLS,
        PH_TAIL,
        PH_DRAIN
    } phase_t;

    // Classified character handed from the front end to the scanner core.
    typedef struct packed {
        logic            eol;
        logic [CU_W-1:0] code;
        logic            ws;
        logic            quote;
        logic            bslash;
        logic            lbrace;
        logic            rbrace;
        logic            colon;
        logic            comma;
        logic            hex_ok;
        logic [3:0]      hex_val;
        logic            esc_ok;
        logic            esc_u;
        logic [CU_W-1:0] esc_val;
    } class_t;

    typedef struct packed {
        kind_t           kind;
        logic [CU_W-1:0] value;
        logic            body_done;
    } result_t;

    function automatic logic is_ws(input logic [CU_W-1:0] c);
        logic r;
        r = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D)
            || (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680)
            || (c >= 16'h2000 && c <= 16'h200A)
            || (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F)
            || (c == 16'h205F) || (c == 16'h3000);
        return r;
    endfunction

endpackage

FILE: sv/jkos_front.sv
// Front end: input handshake and character classification.
module jkos_front (
    input  logic                       push,
    output logic                       full,
    input  logic                       mode,
    input  logic [jkos_pkg::CU_W-1:0]  code_unit,
    input  logic                       q_full,
    output logic                       q_push,
    output jkos_pkg::class_t           q_data
);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data         = '0;
        q_data.eol     = mode;
        q_data.code    = code_unit;
        q_data.ws      = jkos_pkg::is_ws(code_unit);
        q_data.quote   = (code_unit == jkos_pkg::CH_QUOTE);
        q_data.bslash  = (code_unit == jkos_pkg::CH_BSLASH);
        q_data.lbrace  = (code_unit == jkos_pkg::CH_LBRACE);
        q_data.rbrace  = (code_unit == jkos_pkg::CH_RBRACE);
        q_data.colon   = (code_unit == jkos_pkg::CH_COLON);
        q_data.comma   = (code_unit == jkos_pkg::CH_COMMA);

        // Hex digits: letters of either case map to ten and up.
        if (code_unit >= 16'h0030 && code_unit <= 16'h0039)
        begin
            q_data.hex_ok  = 1'b1;
            q_data.hex_val = code_unit[3:0];
        end
        else if ((code_unit >= 16'h0061 && code_unit <= 16'h0066)
                 || (code_unit >= 16'h0041 && code_unit <= 16'h0046))
        begin
            q_data.hex_ok  = 1'b1;
            q_data.hex_val = code_unit[3:0] + 4'd9;
        end

        unique case (code_unit)
            jkos_pkg::CH_QUOTE:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = jkos_pkg::CH_QUOTE;
            end
            jkos_pkg::CH_BSLASH:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = jkos_pkg::CH_BSLASH;
            end
            jkos_pkg::CH_SLASH:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = jkos_pkg::CH_SLASH;
            end
            jkos_pkg::CH_LOW_B:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = 16'h0008;
            end
            jkos_pkg::CH_LOW_F:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = 16'h000C;
            end
            jkos_pkg::CH_LOW_N:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = 16'h000A;
            end
            jkos_pkg::CH_LOW_R:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = 16'h000D;
            end
            jkos_pkg::CH_LOW_T:
            begin
                q_data.esc_ok  = 1'b1;
                q_data.esc_val = 16'h0009;
            end
            jkos_pkg::CH_LOW_U:
            begin
                q_data.esc_u = 1'b1;
            end
            default:
            begin
                q_data.esc_ok = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/jkos_queue.sv
// Short queue of classified characters between the front end and the scanner core.
module jkos_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  jkos_pkg::class_t    wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output logic                q_valid,
    output jkos_pkg::class_t    rd_data
);

    jkos_pkg::class_t                 mem_reg [jkos_pkg::Q_DEPTH];
    logic [jkos_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [jkos_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [jkos_pkg::Q_CNT_W-1:0]     cnt_reg, cnt_next;

    localparam logic [jkos_pkg::Q_PTR_W-1:0] LAST_PTR =
        jkos_pkg::Q_PTR_W'(jkos_pkg::Q_DEPTH - 1);

    assign q_full  = (cnt_reg == jkos_pkg::Q_CNT_W'(jkos_pkg::Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/jkos_back.sv
// Scanner core: line state machine, key unescaping, brace depth and result queue.
module jkos_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  jkos_pkg::class_t           q_data,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 kind,
    output logic [jkos_pkg::CU_W-1:0]  value,
    output logic                       body_done
);

    jkos_pkg::phase_t                 phase_reg, phase_next;
    logic [jkos_pkg::DEPTH_W-1:0]     depth_reg, depth_next;
    logic                             in_str_reg, in_str_next;
    logic                             esc_reg, esc_next;
    logic [1:0]                       hex_cnt_reg, hex_cnt_next;
    logic [jkos_pkg::CU_W-1:0]        hex_acc_reg, hex_acc_next;

    logic                             step;
    logic                             res_valid;
    jkos_pkg::result_t                res;
    logic [jkos_pkg::DEPTH_W-1:0]     depth_dec;
    logic [jkos_pkg::CU_W-1:0]        hex_shift;
    logic                             depth_full;

    jkos_pkg::result_t                out_mem_reg [jkos_pkg::Q_DEPTH];
    logic [jkos_pkg::Q_PTR_W-1:0]     out_wr_reg, out_wr_next;
    logic [jkos_pkg::Q_PTR_W-1:0]     out_rd_reg, out_rd_next;
    logic [jkos_pkg::Q_CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                             out_push;
    logic                             out_pop;
    logic                             out_room;

    localparam logic [jkos_pkg::Q_PTR_W-1:0] LAST_PTR =
        jkos_pkg::Q_PTR_W'(jkos_pkg::Q_DEPTH - 1);

    assign out_pop  = pop && !empty;
    assign out_room = (out_cnt_reg != jkos_pkg::Q_CNT_W'(jkos_pkg::Q_DEPTH)) || out_pop;
    assign step     = q_valid && out_room;
    assign q_pop    = step;
    assign out_push = step && res_valid;

    assign depth_dec  = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;
    assign depth_full = (depth_reg >= jkos_pkg::DEPTH_W'(jkos_pkg::MAX_NESTING));
    assign hex_shift  = {hex_acc_reg[jkos_pkg::CU_W-5:0], q_data.hex_val};

    // Next-state logic.
    always_comb
    begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        in_str_next  = in_str_reg;
        esc_next     = esc_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        if (q_data.eol)
        begin
            phase_next   = jkos_pkg::PH_START;
            depth_next   = '0;
            in_str_next  = 1'b0;
            esc_next     = 1'b0;
            hex_cnt_next = '0;
            hex_acc_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                jkos_pkg::PH_START:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.rbrace)
                        phase_next = jkos_pkg::PH_AFTER_CLS;
                    else if (q_data.quote)
                        phase_next = jkos_pkg::PH_KEY;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_NEXT_KEY:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.quote)
                        phase_next = jkos_pkg::PH_KEY;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_KEY:
                begin
                    if (q_data.quote)
                        phase_next = jkos_pkg::PH_AFTER_KEY;
                    else if (q_data.bslash)
                        phase_next = jkos_pkg::PH_KEY_ESC;
                end
                jkos_pkg::PH_KEY_ESC:
                begin
                    if (q_data.esc_u)
                    begin
                        phase_next   = jkos_pkg::PH_KEY_HEX;
                        hex_cnt_next = '0;
                        hex_acc_next = '0;
                    end
                    else if (q_data.esc_ok)
                        phase_next = jkos_pkg::PH_KEY;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_KEY_HEX:
                begin
                    if (!q_data.hex_ok)
                    begin
                        phase_next   = jkos_pkg::PH_DRAIN;
                        hex_cnt_next = '0;
                        hex_acc_next = '0;
                    end
                    else if (hex_cnt_reg == 2'd3)
                    begin
                        phase_next   = jkos_pkg::PH_KEY;
                        hex_cnt_next = '0;
                        hex_acc_next = '0;
                    end
                    else
                    begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        hex_acc_next = hex_shift;
                    end
                end
                jkos_pkg::PH_AFTER_KEY:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.colon)
                        phase_next = jkos_pkg::PH_AFTER_COL;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_AFTER_COL:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.lbrace)
                    begin
                        phase_next  = jkos_pkg::PH_BODY;
                        depth_next  = jkos_pkg::DEPTH_W'(1);
                        in_str_next = 1'b0;
                        esc_next    = 1'b0;
                    end
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_BODY:
                begin
                    if (in_str_reg)
                    begin
                        if (esc_reg)
                            esc_next = 1'b0;
                        else if (q_data.bslash)
                            esc_next = 1'b1;
                        else if (q_data.quote)
                            in_str_next = 1'b0;
                    end
                    else if (q_data.quote)
                        in_str_next = 1'b1;
                    else if (q_data.lbrace)
                    begin
                        if (depth_full)
                        begin
                            phase_next = jkos_pkg::PH_DRAIN;
                            depth_next = '0;
                            esc_next   = 1'b0;
                        end
                        else
                            depth_next = depth_reg + 1'b1;
                    end
                    else if (q_data.rbrace)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                            phase_next = jkos_pkg::PH_AFTER_BODY;
                    end
                end
                jkos_pkg::PH_AFTER_BODY:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.comma)
                        phase_next = jkos_pkg::PH_NEXT_KEY;
                    else if (q_data.rbrace)
                        phase_next = jkos_pkg::PH_AFTER_CLS;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_AFTER_CLS:
                begin
                    if (q_data.ws)
                        phase_next = phase_reg;
                    else if (q_data.comma)
                        phase_next = jkos_pkg::PH_TAIL;
                    else
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                jkos_pkg::PH_TAIL:
                begin
                    if (!q_data.ws)
                        phase_next = jkos_pkg::PH_DRAIN;
                end
                default:
                begin
                    phase_next = jkos_pkg::PH_DRAIN;
                end
            endcase
        end
    end

    // Result logic.
    always_comb
    begin
        res_valid     = 1'b0;
        res.kind      = jkos_pkg::KIND_ERROR;
        res.value     = '0;
        res.body_done = 1'b0;
        if (q_data.eol)
        begin
            if (phase_reg == jkos_pkg::PH_AFTER_CLS || phase_reg == jkos_pkg::PH_TAIL)
            begin
                res_valid = 1'b1;
                res.kind  = jkos_pkg::KIND_ACCEPT;
            end
            else if (phase_reg != jkos_pkg::PH_DRAIN)
                res_valid = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                jkos_pkg::PH_START:
                    res_valid = !(q_data.ws || q_data.rbrace || q_data.quote);
                jkos_pkg::PH_NEXT_KEY:
                    res_valid = !(q_data.ws || q_data.quote);
                jkos_pkg::PH_KEY:
                begin
                    if (q_data.quote)
                    begin
                        res_valid = 1'b1;
                        res.kind  = jkos_pkg::KIND_KEY_END;
                    end
                    else if (!q_data.bslash)
                    begin
                        res_valid = 1'b1;
                        res.kind  = jkos_pkg::KIND_KEY_CHAR;
                        res.value = q_data.code;
                    end
                end
                jkos_pkg::PH_KEY_ESC:
                begin
                    if (q_data.esc_ok)
                    begin
                        res_valid = 1'b1;
                        res.kind  = jkos_pkg::KIND_KEY_CHAR;
                        res.value = q_data.esc_val;
                    end
                    else if (!q_data.esc_u)
                        res_valid = 1'b1;
                end
                jkos_pkg::PH_KEY_HEX:
                begin
                    if (!q_data.hex_ok)
                        res_valid = 1'b1;
                    else if (hex_cnt_reg == 2'd3)
                    begin
                        res_valid = 1'b1;
                        res.kind  = jkos_pkg::KIND_KEY_CHAR;
                        res.value = hex_shift;
                    end
                end
                jkos_pkg::PH_AFTER_KEY:
                    res_valid = !(q_data.ws || q_data.colon);
                jkos_pkg::PH_AFTER_COL:
                begin
                    if (q_data.lbrace)
                    begin
                        res_valid = 1'b1;
                        res.kind  = jkos_pkg::KIND_BODY;
                        res.value = q_data.code;
                    end
                    else
                        res_valid = !q_data.ws;
                end
                jkos_pkg::PH_BODY:
                begin
                    res_valid = 1'b1;
                    // An opening brace at full depth is the only error inside a body.
                    if (in_str_reg || !q_data.lbrace || !depth_full)
                    begin
                        res.kind  = jkos_pkg::KIND_BODY;
                        res.value = q_data.code;
                        res.body_done = !in_str_reg && q_data.rbrace && (depth_dec == '0);
                    end
                end
                jkos_pkg::PH_AFTER_BODY:
                    res_valid = !(q_data.ws || q_data.comma || q_data.rbrace);
                jkos_pkg::PH_AFTER_CLS:
                    res_valid = !(q_data.ws || q_data.comma);
                jkos_pkg::PH_TAIL:
                    res_valid = !q_data.ws;
                default:
                    res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= jkos_pkg::PH_START;
            depth_reg   <= '0;
            in_str_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            hex_cnt_reg <= '0;
            hex_acc_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            depth_reg   <= depth_next;
            in_str_reg  <= in_str_next;
            esc_reg     <= esc_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
        end
    end

    // Result queue; a slot freed by a pop can be refilled in the same cycle.
    assign empty     = (out_cnt_reg == '0);
    assign kind      = out_mem_reg[out_rd_reg].kind;
    assign value     = out_mem_reg[out_rd_reg].value;
    assign body_done = out_mem_reg[out_rd_reg].body_done;

    always_comb
    begin
        out_wr_next  = out_wr_reg;
        out_rd_next  = out_rd_reg;
        out_cnt_next = out_cnt_reg;
        if (out_push)
            out_wr_next = (out_wr_reg == LAST_PTR) ? '0 : out_wr_reg + 1'b1;
        if (out_pop)
            out_rd_next = (out_rd_reg == LAST_PTR) ? '0 : out_rd_reg + 1'b1;
        if (out_push && !out_pop)
            out_cnt_next = out_cnt_reg + 1'b1;
        else if (out_pop && !out_push)
            out_cnt_next = out_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            out_wr_reg  <= out_wr_next;
            out_rd_reg  <= out_rd_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            out_mem_reg[out_wr_reg] <= res;
    end

endmodule

FILE: sv/json_keyed_object_line_scanner.sv
// Top level of the keyed-object line scanner: front end, character queue, scanner core.
//
//  channel   handshake          fields
//  input     push / full        mode, code_unit
//  result    empty / pop        kind, value, body_done
//
// One item per clock unless a stalled reader fills the result queue; each character
// needs one scanner-core step. An accepted item passes the character queue and then
// the result queue on its way to the result ports. The character queue and the result
// queue hold two items each, so a stalled reader fills both before full rises. Reset
// is asynchronous and returns the scanner to line start with both queues empty.
module json_keyed_object_line_scanner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       mode,
    input  logic [jkos_pkg::CU_W-1:0]  code_unit,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 kind,
    output logic [jkos_pkg::CU_W-1:0]  value,
    output logic                       body_done
);

    logic              q_full;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;
    jkos_pkg::class_t  q_wr_data;
    jkos_pkg::class_t  q_rd_data;

    jkos_front u_front (
        .push      (push),
        .full      (full),
        .mode      (mode),
        .code_unit (code_unit),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    jkos_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_data (q_rd_data)
    );

    jkos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .kind      (kind),
        .value     (value),
        .body_done (body_done)
    );

endmodule

FILE: sv/jkos_checker.sv
// Port-level checker for the keyed-object line scanner and its bind.
`include "json_keyed_object_line_scanner_defines.svh"

module jkos_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       empty,
    input  logic                       pop,
    input  logic [2:0]                 kind,
    input  logic [jkos_pkg::CU_W-1:0]  value,
    input  logic                       body_done
);

    logic                       body_shown;
    logic                       done_shown;
    logic                       marker_shown;
    logic                       payload_zero;
    logic                       result_held;
    logic [jkos_pkg::CU_W+3:0]  shown;

    assign body_shown   = !empty && (kind == jkos_pkg::KIND_BODY);
    assign done_shown   = !empty && body_done;
    assign marker_shown = !empty && (kind == jkos_pkg::KIND_KEY_END
                                     || kind == jkos_pkg::KIND_ACCEPT
                                     || kind == jkos_pkg::KIND_ERROR);
    assign payload_zero = (value == '0) && !body_done;
    assign result_held  = !empty && !pop;
    assign shown        = {kind, value, body_done};

    `JKOS_ASSERT_ALWAYS(a_empty_in_reset, clk, !rst_n |=> empty, "results left after reset")

    `JKOS_ASSERT(a_done_is_body, clk, rst_n, done_shown |-> body_shown, "body_done off a body char")

    `JKOS_ASSERT(a_value_zero, clk, rst_n, marker_shown |-> payload_zero, "payload on a marker")

    `JKOS_ASSERT(a_result_holds, clk, rst_n, result_held |=> (!empty && $stable(shown)), "result moved")

endmodule

bind json_keyed_object_line_scanner jkos_checker u_jkos_checker (.*);
